[rtl/core/sntp_pkg.sv]
// Package for the SNTP response checker: shared constants, status codes,
// the packet record type passed from front to back, and the epoch helper.
// No dependencies.
package sntp_pkg;

  // Packet size and queue depth defaults for the top-level parameters
  localparam int PACKET_BYTES_DEF = 48;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Byte counter saturates at its all-ones value
  localparam int         COUNT_W   = 6;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  // Field checks
  localparam logic [2:0]  MODE_SERVER = 3'd4;
  localparam logic [7:0]  STRATUM_MAX = 8'd15;
  localparam logic [31:0] NTP_TO_UNIX = 32'd2208988800;

  // Byte positions of the captured header fields
  localparam logic [5:0] MODE_BYTE    = 6'd0;
  localparam logic [5:0] STRATUM_BYTE = 6'd1;
  // 4-byte word slots (byte index / 4)
  localparam logic [3:0] ORIG_SLOT = 4'd6;
  localparam logic [3:0] FRAC_SLOT = 4'd7;
  localparam logic [3:0] RECV_SLOT = 4'd8;
  localparam logic [3:0] XMIT_SLOT = 4'd10;

  localparam int OFFSET_W = 34;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  // One finished packet, classified by the front end
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] orig_raw;
    logic [31:0] frac_raw;
    logic [31:0] recv_raw;
    logic [31:0] xmit_raw;
    logic [31:0] t4;
  } rec_t;

  // NTP seconds to Unix seconds, clamped at the epoch
  function automatic logic [31:0] to_unix(input logic [31:0] sec);
    return (sec < NTP_TO_UNIX) ? 32'd0 : sec - NTP_TO_UNIX;
  endfunction

endpackage

[rtl/core/sntp_if.sv]
// Valid/ready channel interfaces for packet bytes in and results out.
// Depends on nothing.
interface sntp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic [31:0] client_receive_seconds;

  modport source(output valid, byte_value, last_byte, client_receive_seconds, input ready);
  modport sink(input valid, byte_value, last_byte, client_receive_seconds, output ready);
endinterface

interface sntp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        originate_seconds;
  logic [31:0]        originate_fraction;
  logic [31:0]        receive_seconds;
  logic [31:0]        transmit_seconds;
  logic signed [33:0] clock_offset;
  logic               synced;

  modport source(output valid, status, originate_seconds, originate_fraction,
                 receive_seconds, transmit_seconds, clock_offset, synced,
                 input ready);
  modport sink(input valid, status, originate_seconds, originate_fraction,
               receive_seconds, transmit_seconds, clock_offset, synced,
               output ready);
endinterface

[rtl/core/sntp_front.sv]
// Front end: counts packet bytes, captures header fields and classifies
// the packet on its last byte. Depends on sntp_pkg and sntp_in_if.
module sntp_front #(
  parameter int PACKET_BYTES = sntp_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sntp_in_if.sink     pkt,
  input  logic        full,
  output logic        push,
  output sntp_pkg::rec_t push_rec
);

  localparam logic [5:0] LAST_IDX = 6'(PACKET_BYTES - 1);
  localparam logic [5:0] PKT_LEN  = 6'(PACKET_BYTES);

  logic [5:0]  byte_count;
  logic [5:0]  byte_count_next;
  logic [2:0]  mode_field;
  logic [7:0]  stratum_field;
  logic [31:0] orig_raw;
  logic [31:0] frac_raw;
  logic [31:0] recv_raw;
  logic [31:0] xmit_raw;
  logic        accept;
  logic        in_pkt;
  logic [3:0]  slot;
  logic        bad_fields;

  assign pkt.ready = !full;
  assign accept    = pkt.valid && pkt.ready;
  assign in_pkt    = byte_count < PKT_LEN;
  assign slot      = byte_count[5:2];

  // Next byte index: saturate, back to zero after a last byte
  always_comb begin
    if (pkt.last_byte) begin
      byte_count_next = '0;
    end else if (byte_count == sntp_pkg::COUNT_MAX) begin
      byte_count_next = byte_count;
    end else begin
      byte_count_next = byte_count + 6'd1;
    end
  end

  // Counter and field capture
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      mode_field    <= '0;
      stratum_field <= '0;
      orig_raw      <= '0;
      frac_raw      <= '0;
      recv_raw      <= '0;
      xmit_raw      <= '0;
    end else if (accept) begin
      byte_count <= byte_count_next;
      if (in_pkt) begin
        if (byte_count == sntp_pkg::MODE_BYTE) begin
          mode_field <= pkt.byte_value[2:0];
        end
        if (byte_count == sntp_pkg::STRATUM_BYTE) begin
          stratum_field <= pkt.byte_value;
        end
        if (slot == sntp_pkg::ORIG_SLOT) begin
          orig_raw <= {orig_raw[23:0], pkt.byte_value};
        end
        if (slot == sntp_pkg::FRAC_SLOT) begin
          frac_raw <= {frac_raw[23:0], pkt.byte_value};
        end
        if (slot == sntp_pkg::RECV_SLOT) begin
          recv_raw <= {recv_raw[23:0], pkt.byte_value};
        end
        if (slot == sntp_pkg::XMIT_SLOT) begin
          xmit_raw <= {xmit_raw[23:0], pkt.byte_value};
        end
      end
    end
  end

  // Classification; fields are complete when the last byte sits at LAST_IDX
  assign bad_fields = (mode_field != sntp_pkg::MODE_SERVER) ||
                      (stratum_field == 8'd0) ||
                      (stratum_field > sntp_pkg::STRATUM_MAX) ||
                      (xmit_raw < sntp_pkg::NTP_TO_UNIX);

  always_comb begin
    push_rec.orig_raw = orig_raw;
    push_rec.frac_raw = frac_raw;
    push_rec.recv_raw = recv_raw;
    push_rec.xmit_raw = xmit_raw;
    push_rec.t4       = pkt.client_receive_seconds;
    priority if (byte_count != LAST_IDX) begin
      push_rec.status = sntp_pkg::STATUS_LENGTH;
    end else if (bad_fields) begin
      push_rec.status = sntp_pkg::STATUS_REJECT;
    end else begin
      push_rec.status = sntp_pkg::STATUS_OK;
    end
  end

  assign push = accept && pkt.last_byte;

endmodule

[rtl/core/sntp_queue.sv]
// Small FIFO of classified packet records between front and back end.
// Depends on sntp_pkg.
module sntp_queue #(
  parameter int DEPTH = sntp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sntp_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sntp_pkg::rec_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sntp_pkg::rec_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

[rtl/core/sntp_back.sv]
// Back end: epoch conversion, offset arithmetic and the result register.
// Holds the offset and synced state. Depends on sntp_pkg and sntp_out_if.
module sntp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  sntp_pkg::rec_t head,
  output logic           pop,
  sntp_out_if.source     res
);

  localparam int OW = sntp_pkg::OFFSET_W;

  logic advance;

  // Stage 1: Unix seconds
  logic        v1;
  logic [1:0]  s1_status;
  logic [31:0] s1_o, s1_f, s1_r, s1_t, s1_t4;

  // Stage 2: partial differences
  logic               v2;
  logic [1:0]         s2_status;
  logic [31:0]        s2_o, s2_f, s2_r, s2_t;
  logic signed [32:0] s2_a, s2_b;

  // Offset state
  logic signed [OW-1:0] offset_store;
  logic                 synced_flag;

  // Final sum and halving toward zero
  logic signed [OW:0]   sum;
  logic signed [OW:0]   sum_adj;
  logic signed [OW-1:0] half;

  logic is_ok;

  assign advance = !res.valid || res.ready;
  assign pop     = advance && !empty;
  assign is_ok   = (head.status == sntp_pkg::STATUS_OK);

  // Stage 1: convert timestamps, zero them for rejected and wrong-length packets
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_status <= head.status;
      s1_t4     <= head.t4;
      s1_o      <= is_ok ? sntp_pkg::to_unix(head.orig_raw) : 32'd0;
      s1_f      <= is_ok ? head.frac_raw : 32'd0;
      s1_r      <= is_ok ? sntp_pkg::to_unix(head.recv_raw) : 32'd0;
      s1_t      <= is_ok ? sntp_pkg::to_unix(head.xmit_raw) : 32'd0;
    end
  end

  // Stage 2: T2-T1 and T3-T4
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_status <= s1_status;
      s2_o      <= s1_o;
      s2_f      <= s1_f;
      s2_r      <= s1_r;
      s2_t      <= s1_t;
      s2_a      <= $signed({1'b0, s1_r}) - $signed({1'b0, s1_o});
      s2_b      <= $signed({1'b0, s1_t}) - $signed({1'b0, s1_t4});
    end
  end

  // Sum, then divide by two truncating toward zero
  assign sum     = $signed({{(OW-32){s2_a[32]}}, s2_a}) + $signed({{(OW-32){s2_b[32]}}, s2_b});
  assign sum_adj = sum + $signed({{OW{1'b0}}, sum[OW]});
  assign half    = OW'(sum_adj >>> 1);

  // Offset state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid    <= 1'b0;
      offset_store <= '0;
      synced_flag  <= 1'b0;
    end else if (advance) begin
      res.valid <= v2;
      if (v2 && (s2_status == sntp_pkg::STATUS_OK)) begin
        offset_store <= half;
        synced_flag  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.status             <= s2_status;
      res.originate_seconds  <= s2_o;
      res.originate_fraction <= s2_f;
      res.receive_seconds    <= s2_r;
      res.transmit_seconds   <= s2_t;
      if (s2_status == sntp_pkg::STATUS_OK) begin
        res.clock_offset <= half;
        res.synced       <= 1'b1;
      end else begin
        res.clock_offset <= offset_store;
        res.synced       <= synced_flag;
      end
    end
  end

endmodule

[rtl/core/sntp_response_check_and_offset.sv]
// A record passes the queue, stage 1, stage 2 and the result register.
// One packet byte per cycle while the queue has room; a result per last byte.
// The four-entry record queue lets byte intake continue while results stall.
// Reset (rst, synchronous): byte count, offset and synced flag cleared,
// queue and result pipeline emptied.
module sntp_response_check_and_offset #(
  parameter int PACKET_BYTES = sntp_pkg::PACKET_BYTES_DEF,
  parameter int QUEUE_DEPTH  = sntp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sntp_in_if.sink    pkt,
  sntp_out_if.source res
);

  sntp_pkg::rec_t push_rec;
  sntp_pkg::rec_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  // Byte capture and classification
  sntp_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .full     (full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Record queue
  sntp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // Offset arithmetic and result
  sntp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

endmodule

[rtl/core/sntp_checker.sv]
// Port-level checks on the result channel of the SNTP checker, bound to
// the top level. Depends on sntp_pkg.
module sntp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] originate_seconds,
  input logic [31:0] originate_fraction,
  input logic [31:0] receive_seconds,
  input logic [31:0] transmit_seconds,
  input logic [33:0] clock_offset,
  input logic        synced
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(clock_offset))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An accepted packet always reports synced
  a_synced: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sntp_pkg::STATUS_OK) |-> synced)
    else $error("accepted packet without synced");

  // Rejected and wrong-length packets carry zero timestamps
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != sntp_pkg::STATUS_OK) |->
      (originate_seconds == 32'd0) && (originate_fraction == 32'd0) &&
      (receive_seconds == 32'd0) && (transmit_seconds == 32'd0))
    else $error("rejected packet with nonzero timestamps");

endmodule

bind sntp_response_check_and_offset sntp_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (res.valid),
  .out_ready          (res.ready),
  .status             (res.status),
  .originate_seconds  (res.originate_seconds),
  .originate_fraction (res.originate_fraction),
  .receive_seconds    (res.receive_seconds),
  .transmit_seconds   (res.transmit_seconds),
  .clock_offset       (res.clock_offset),
  .synced             (res.synced)
);

[verif/sntp_response_check_and_offset_tb.sv]
// Self-checking testbench for sntp_response_check_and_offset: sends SNTP frames byte by
// byte and checks every packet result against a local model of the checker and offset math.
// Depends on sntp_pkg, sntp_in_if / sntp_out_if and the block itself.
module sntp_response_check_and_offset_tb;

  localparam int          FRAME_BYTES = sntp_pkg::PACKET_BYTES_DEF;
  localparam int          LATENCY     = 3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned PAUSE_AT    = 1000;

  // One packet result as the block reports it
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        orig_s;
    logic [31:0]        frac;
    logic [31:0]        recv_s;
    logic [31:0]        xmit_s;
    logic signed [33:0] offset;
    logic               synced;
  } sntp_result_t;

  // One frame to send; want is used only where typed is set
  typedef struct {
    int unsigned  nbytes;
    logic [7:0]   mode_byte;
    logic [7:0]   stratum;
    logic [31:0]  orig;
    logic [31:0]  frac;
    logic [31:0]  recv;
    logic [31:0]  xmit;
    logic [31:0]  t4;
    bit           typed;
    sntp_result_t want;
  } pkt_row_t;

  localparam sntp_result_t LEN_FAIL     = '{status: sntp_pkg::STATUS_LENGTH, default: '0};
  localparam sntp_result_t REJECT_FRESH = '{status: sntp_pkg::STATUS_REJECT, default: '0};

  logic clk = 1'b0;
  logic rst;

  sntp_in_if  pkt ();
  sntp_out_if res ();

  sntp_response_check_and_offset i_dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt),
    .res (res)
  );

  always #5 clk = ~clk;

  // Model state of the checker
  logic [5:0]         seen_count;
  logic [2:0]         seen_mode;
  logic [7:0]         seen_stratum;
  logic [31:0]        seen_orig;
  logic [31:0]        seen_frac;
  logic [31:0]        seen_recv;
  logic [31:0]        seen_xmit;
  logic signed [33:0] held_offset;
  logic               held_synced;

  sntp_result_t results_due[$];
  int unsigned  fails;
  int unsigned  cycle_count;
  bit           steady;
  pkt_row_t     directed[$];

  function automatic logic [31:0] unix_from_ntp(input logic [31:0] sec);
    if (sec < sntp_pkg::NTP_TO_UNIX) return 32'd0;
    return sec - sntp_pkg::NTP_TO_UNIX;
  endfunction

  // Advance the model by one byte; returns 1 when the byte closes a packet
  function automatic bit track_packet_byte(input logic [7:0] b, input logic last,
                                           input logic [31:0] t4,
                                           output sntp_result_t verdict);
    logic [5:0]  idx;
    int unsigned len;
    longint      span;
    idx = seen_count;
    verdict = '0;
    if (idx < FRAME_BYTES) begin
      if (idx == sntp_pkg::MODE_BYTE) seen_mode = b[2:0];
      else if (idx == sntp_pkg::STRATUM_BYTE) seen_stratum = b;
      else begin
        case (idx[5:2])
          sntp_pkg::ORIG_SLOT: seen_orig = {seen_orig[23:0], b};
          sntp_pkg::FRAC_SLOT: seen_frac = {seen_frac[23:0], b};
          sntp_pkg::RECV_SLOT: seen_recv = {seen_recv[23:0], b};
          sntp_pkg::XMIT_SLOT: seen_xmit = {seen_xmit[23:0], b};
          default: ;
        endcase
      end
    end
    len = idx + 1;
    seen_count = (idx < sntp_pkg::COUNT_MAX) ? idx + 6'd1 : sntp_pkg::COUNT_MAX;
    if (!last) return 1'b0;
    seen_count = '0;
    if (len != FRAME_BYTES) begin
      verdict.status = sntp_pkg::STATUS_LENGTH;
    end else if (seen_mode != sntp_pkg::MODE_SERVER || seen_stratum == 8'd0 ||
                 seen_stratum > sntp_pkg::STRATUM_MAX ||
                 seen_xmit < sntp_pkg::NTP_TO_UNIX) begin
      verdict.status = sntp_pkg::STATUS_REJECT;
    end else begin
      verdict.status = sntp_pkg::STATUS_OK;
      verdict.orig_s = unix_from_ntp(seen_orig);
      verdict.frac   = seen_frac;
      verdict.recv_s = unix_from_ntp(seen_recv);
      verdict.xmit_s = unix_from_ntp(seen_xmit);
      // ((T2-T1)+(T3-T4))/2, truncated toward zero
      span = (longint'({32'd0, verdict.recv_s}) - longint'({32'd0, verdict.orig_s})) +
             (longint'({32'd0, verdict.xmit_s}) - longint'({32'd0, t4}));
      held_offset = 34'(span / 2);
      held_synced = 1'b1;
    end
    verdict.offset = held_offset;
    verdict.synced = held_synced;
    return 1'b1;
  endfunction

  function automatic pkt_row_t frame_row(input int unsigned n, input logic [7:0] m,
                                         input logic [7:0] s, input logic [31:0] o,
                                         input logic [31:0] f, input logic [31:0] r,
                                         input logic [31:0] x, input logic [31:0] t4,
                                         input bit typed = 1'b0,
                                         input sntp_result_t want = '0);
    pkt_row_t row;
    row.nbytes = n;    row.mode_byte = m; row.stratum = s;
    row.orig = o;      row.frac = f;      row.recv = r;
    row.xmit = x;      row.t4 = t4;
    row.typed = typed; row.want = want;
    return row;
  endfunction

  // Wire byte i of a frame: header fields at their slots, filler elsewhere
  function automatic logic [7:0] frame_byte(input pkt_row_t row, input int i);
    logic [3:0] slot;
    int         lane;
    slot = 4'(i / 4);
    lane = 8 * (3 - i % 4);
    if (i == sntp_pkg::MODE_BYTE) return row.mode_byte;
    if (i == sntp_pkg::STRATUM_BYTE) return row.stratum;
    if (i < FRAME_BYTES) begin
      if (slot == sntp_pkg::ORIG_SLOT) return row.orig[lane +: 8];
      if (slot == sntp_pkg::FRAC_SLOT) return row.frac[lane +: 8];
      if (slot == sntp_pkg::RECV_SLOT) return row.recv[lane +: 8];
      if (slot == sntp_pkg::XMIT_SLOT) return row.xmit[lane +: 8];
    end
    return 8'($urandom);
  endfunction

  // Mostly short gaps, a few long ones, none in steady stretches
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (steady || k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Timestamp words: mostly after the epoch, some around it, some extremes
  function automatic logic [31:0] pick_stamp();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 65) return $urandom_range(sntp_pkg::NTP_TO_UNIX, 32'hFFFF_FFFF);
    if (k < 80) return $urandom;
    if (k < 92) return 32'(sntp_pkg::NTP_TO_UNIX + $urandom_range(0, 2) - 1);
    return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  // Random frames: length, mode and stratum each valid most of the time
  function automatic pkt_row_t random_row();
    pkt_row_t    row;
    int unsigned k;
    k = $urandom_range(0, 99);
    row = frame_row(FRAME_BYTES, 8'($urandom), 8'($urandom), pick_stamp(), $urandom,
                    pick_stamp(), pick_stamp(), $urandom);
    if (k >= 72) begin
      row.nbytes = (k < 86) ? $urandom_range(1, FRAME_BYTES - 1)
                            : $urandom_range(FRAME_BYTES + 1, 75);
    end
    if ($urandom_range(0, 9) < 8) row.mode_byte[2:0] = sntp_pkg::MODE_SERVER;
    if ($urandom_range(0, 9) < 8) row.stratum = 8'($urandom_range(1, sntp_pkg::STRATUM_MAX));
    if ($urandom_range(0, 1)) begin
      row.t4 = 32'(row.xmit - sntp_pkg::NTP_TO_UNIX + $urandom_range(0, 8));
    end
    return row;
  endfunction

  // Drive one byte and return at the edge where the transaction is accepted
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] t4);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pkt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt.valid                  <= 1'b1;
    pkt.byte_value             <= b;
    pkt.last_byte              <= last;
    pkt.client_receive_seconds <= t4;
    do @(posedge clk); while (!pkt.ready);
  endtask

  task automatic send_frame(input pkt_row_t row);
    sntp_result_t guess;
    logic [7:0]   b;
    logic         last;
    logic [31:0]  t4;
    for (int i = 0; i < row.nbytes; i++) begin
      b    = frame_byte(row, i);
      last = (i == row.nbytes - 1);
      t4   = last ? row.t4 : $urandom;
      send_byte(b, last, t4);
      if (track_packet_byte(b, last, t4, guess)) begin
        results_due.push_back(row.typed ? row.want : guess);
      end
    end
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    pkt.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() > 0);
  endtask

  // Result side: random stalls on ready
  initial begin
    int unsigned hold;
    hold = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = 1 + pick_gap();
      end
    end
  end

  // Compare each accepted result transaction with the oldest pending one
  always @(posedge clk) begin
    sntp_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, res.status);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (res.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res.status);
          fails++;
        end
        if (res.originate_seconds !== want.orig_s) begin
          $display("%0t: originate_seconds expected %0h got %0h", $time, want.orig_s,
                   res.originate_seconds);
          fails++;
        end
        if (res.originate_fraction !== want.frac) begin
          $display("%0t: originate_fraction expected %0h got %0h", $time, want.frac,
                   res.originate_fraction);
          fails++;
        end
        if (res.receive_seconds !== want.recv_s) begin
          $display("%0t: receive_seconds expected %0h got %0h", $time, want.recv_s,
                   res.receive_seconds);
          fails++;
        end
        if (res.transmit_seconds !== want.xmit_s) begin
          $display("%0t: transmit_seconds expected %0h got %0h", $time, want.xmit_s,
                   res.transmit_seconds);
          fails++;
        end
        if (res.clock_offset !== want.offset) begin
          $display("%0t: clock_offset expected %0d got %0d", $time, want.offset,
                   res.clock_offset);
          fails++;
        end
        if (res.synced !== want.synced) begin
          $display("%0t: synced expected %0b got %0b", $time, want.synced, res.synced);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pkt_row_t    row;
    int unsigned sent_items;
    bit          paused;
    sent_items   = 0;
    paused       = 1'b0;
    fails        = 0;
    cycle_count  = 0;
    steady       = 1'b0;
    seen_count   = '0;
    seen_mode    = '0;
    seen_stratum = '0;
    seen_orig    = '0;
    seen_frac    = '0;
    seen_recv    = '0;
    seen_xmit    = '0;
    held_offset  = '0;
    held_synced  = 1'b0;
    rst                        <= 1'b1;
    pkt.valid                  <= 1'b0;
    pkt.byte_value             <= '0;
    pkt.last_byte              <= 1'b0;
    pkt.client_receive_seconds <= '0;

    // Directed frames: wrong lengths, each reject reason, then the offset corners
    directed.push_back(frame_row(1, 8'h24, 8'h01, 0, 0, 0, 0, 0, 1, LEN_FAIL));
    directed.push_back(frame_row(47, 8'h24, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, LEN_FAIL));
    directed.push_back(frame_row(49, 8'h24, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, LEN_FAIL));
    directed.push_back(frame_row(63, 8'h24, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, LEN_FAIL));
    // past the count saturation point
    directed.push_back(frame_row(75, 8'h24, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, LEN_FAIL));
    directed.push_back(frame_row(48, 8'h23, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1,
                                 REJECT_FRESH));
    directed.push_back(frame_row(48, 8'h00, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0, 1,
                                 REJECT_FRESH));
    directed.push_back(frame_row(48, 8'h24, 8'h00, 0, 0, 0, 32'hFFFF_FFFF, 0, 1,
                                 REJECT_FRESH));
    directed.push_back(frame_row(48, 8'h24, 8'h10, 0, 0, 0, 32'hFFFF_FFFF, 0, 1,
                                 REJECT_FRESH));
    directed.push_back(frame_row(48, 8'h24, 8'hFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 1,
                                 REJECT_FRESH));
    directed.push_back(frame_row(48, 8'h24, 8'h01, 0, 0, 0, sntp_pkg::NTP_TO_UNIX - 1, 0,
                                 1, REJECT_FRESH));
    // all stamps at the epoch: first accept, zero offset
    directed.push_back(frame_row(48, 8'h24, 8'h01, sntp_pkg::NTP_TO_UNIX, 32'hFFFF_FFFF,
                                 sntp_pkg::NTP_TO_UNIX, sntp_pkg::NTP_TO_UNIX, 0, 1,
                                 '{sntp_pkg::STATUS_OK, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                   34'sd0, 1'b1}));
    // largest positive offset, mode with high bits set, top stratum
    directed.push_back(frame_row(48, 8'hFC, 8'h0F, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    // most negative offset
    directed.push_back(frame_row(48, 8'h24, 8'h02, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 0,
                                 sntp_pkg::NTP_TO_UNIX, 32'hFFFF_FFFF));
    // reject and bad length after sync keep the held offset
    directed.push_back(frame_row(48, 8'h24, 8'h00, 0, 0, 0, 32'hFFFF_FFFF, 0));
    directed.push_back(frame_row(20, 8'h24, 8'h01, 0, 0, 0, 32'hFFFF_FFFF, 0));
    // odd negative sum truncates toward zero
    directed.push_back(frame_row(48, 8'h24, 8'h03, sntp_pkg::NTP_TO_UNIX + 3, 32'h0000_0001,
                                 sntp_pkg::NTP_TO_UNIX, sntp_pkg::NTP_TO_UNIX, 0));
    directed.push_back(frame_row(48, 8'h7C, 8'h01, sntp_pkg::NTP_TO_UNIX + 100,
                                 32'h1234_5678, sntp_pkg::NTP_TO_UNIX + 105,
                                 sntp_pkg::NTP_TO_UNIX + 106, 110));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      steady = ($urandom_range(0, 3) == 0);
      send_frame(directed[k]);
      sent_items += directed[k].nbytes;
    end
    drain_results();

    // Random frames up to the item budget
    while (sent_items < ITEM_TARGET) begin
      row    = random_row();
      steady = ($urandom_range(0, 4) == 0);
      send_frame(row);
      sent_items += row.nbytes;
      if (!paused && sent_items >= PAUSE_AT) begin
        drain_results();
        paused = 1'b1;
      end
    end

    pkt.valid <= 1'b0;
    while (results_due.size() > 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
